>>> hdl/prit_pkg.sv
// Shared constants, operation and status codes and the table entry layout
// for the pending request id table. No dependencies.
package prit_pkg;

   localparam int ID_COUNT_DEF = 256;

   localparam int FUNC_W   = 2;
   localparam int ADDR_W   = 32;
   localparam int PORT_W   = 16;
   localparam int CID_W    = 8;
   localparam int TIME_W   = 32;
   localparam int FID_W    = 8;
   localparam int STATUS_W = 3;
   localparam int ID_W     = 8;

   localparam logic [TIME_W-1:0] MAX_AGE_RST = TIME_W'(30);

   localparam logic [FUNC_W-1:0] FUNC_FORWARD = FUNC_W'(0);
   localparam logic [FUNC_W-1:0] FUNC_REPLY   = FUNC_W'(1);
   localparam logic [FUNC_W-1:0] FUNC_REQUEUE = FUNC_W'(2);
   localparam logic [FUNC_W-1:0] FUNC_UNUSED  = FUNC_W'(3);

   localparam logic [STATUS_W-1:0] ST_ALLOC    = STATUS_W'(0);
   localparam logic [STATUS_W-1:0] ST_DUP      = STATUS_W'(1);
   localparam logic [STATUS_W-1:0] ST_FULL     = STATUS_W'(2);
   localparam logic [STATUS_W-1:0] ST_MATCH    = STATUS_W'(3);
   localparam logic [STATUS_W-1:0] ST_NOMATCH  = STATUS_W'(4);
   localparam logic [STATUS_W-1:0] ST_REQUEUED = STATUS_W'(5);
   localparam logic [STATUS_W-1:0] ST_STALE    = STATUS_W'(6);

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [PORT_W-1:0] port;
      logic [CID_W-1:0]  cid;
      logic [TIME_W-1:0] stamp;
   } entry_type;

endpackage

>>> hdl/prit_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// Stand-alone; no package dependencies.
module prit_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/pending_request_id_table_unit.sv
// Top level of the pending request id table: sweep sequencer, valid bits and result register.
// Depends on prit_pkg and prit_ram.
//
// Keeps up to ID_COUNT forwarded requests, one per forwarded id; the entry contents sit in
// one RAM with a registered read and the valid bits in flip-flops, which reset clears at
// once, so the block takes words straight after reset. For a forward word the sequencer
// reads every entry once through the single RAM read port, starting at the rotating
// allocation pointer, expires it, checks it for a duplicate and notes the first free id in
// the same pass, then writes the new entry if it found no duplicate and a free id. The
// next word is taken while a result still waits on the rsp side; a result waits only
// when the previous one has not been taken. max_age may be written through the csr port
// between words.
module pending_request_id_table_unit #(
   parameter int ID_COUNT = prit_pkg::ID_COUNT_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [prit_pkg::FUNC_W-1:0]   req_func,
   input  logic [prit_pkg::ADDR_W-1:0]   req_client_addr,
   input  logic [prit_pkg::PORT_W-1:0]   req_client_port,
   input  logic [prit_pkg::CID_W-1:0]    req_client_id,
   input  logic [prit_pkg::TIME_W-1:0]   req_stamp,
   input  logic [prit_pkg::TIME_W-1:0]   req_now,
   input  logic [prit_pkg::FID_W-1:0]    req_fwd_id,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [prit_pkg::STATUS_W-1:0] rsp_status,
   output logic [prit_pkg::ID_W-1:0]     rsp_out_id,
   output logic [prit_pkg::ADDR_W-1:0]   rsp_out_addr,
   output logic [prit_pkg::PORT_W-1:0]   rsp_out_port,
   output logic [prit_pkg::CID_W-1:0]    rsp_out_client_id,
   output logic [prit_pkg::TIME_W-1:0]   rsp_out_stamp,
   input  logic                          csr_wr_en,
   input  logic [prit_pkg::TIME_W-1:0]   csr_wr_data
);

   localparam int IW   = $clog2(ID_COUNT);
   localparam int EW   = $bits(prit_pkg::entry_type);
   localparam int IDW  = prit_pkg::ID_W;
   localparam int FW1  = prit_pkg::FID_W + 1;
   localparam logic [IW:0]    ID_LIM    = (IW+1)'(ID_COUNT);
   localparam logic [IW-1:0]  ID_LAST   = IW'(ID_COUNT - 1);
   localparam logic [FW1-1:0] FID_BOUND = FW1'(ID_COUNT);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SWEEP,
      S_LAST,
      S_FWD_DONE,
      S_REPLY,
      S_SIMPLE
   } state_type;

   state_type                     state_ff, state_in;
   logic [prit_pkg::TIME_W-1:0]   max_age_ff, max_age_in;
   logic [IW-1:0]                 next_id_ff, next_id_in;
   logic [ID_COUNT-1:0]           valid_ff, valid_in;
   logic [IW-1:0]                 cnt_ff, cnt_in;
   logic                          chk_ff, chk_in;
   logic [IW-1:0]                 chk_idx_ff, chk_idx_in;
   logic                          chk_vld_ff, chk_vld_in;
   logic                          dup_found_ff, dup_found_in;
   logic [IW-1:0]                 dup_idx_ff, dup_idx_in;
   logic                          free_found_ff, free_found_in;
   logic [IW-1:0]                 free_idx_ff, free_idx_in;
   logic                          hit_ff, hit_in;

   logic [prit_pkg::FUNC_W-1:0]   func_ff, func_in;
   logic [prit_pkg::ADDR_W-1:0]   addr_ff, addr_in;
   logic [prit_pkg::PORT_W-1:0]   port_ff, port_in;
   logic [prit_pkg::CID_W-1:0]    cid_ff, cid_in;
   logic [prit_pkg::TIME_W-1:0]   stamp_ff, stamp_in;
   logic [prit_pkg::TIME_W-1:0]   now_ff, now_in;
   logic [IW-1:0]                 fid_idx_ff, fid_idx_in;
   logic                          fid_ok_ff, fid_ok_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [prit_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [IDW-1:0]                rsp_id_ff, rsp_id_in;
   logic [prit_pkg::ADDR_W-1:0]   rsp_addr_ff, rsp_addr_in;
   logic [prit_pkg::PORT_W-1:0]   rsp_port_ff, rsp_port_in;
   logic [prit_pkg::CID_W-1:0]    rsp_cid_ff, rsp_cid_in;
   logic [prit_pkg::TIME_W-1:0]   rsp_stamp_ff, rsp_stamp_in;

   logic                          req_take;
   logic                          out_free;
   logic [IW:0]                   sw_sum;
   logic [IW-1:0]                 sw_addr;
   logic [IW-1:0]                 req_idx;
   logic                          req_fid_ok;
   logic [EW-1:0]                 rd_word;
   prit_pkg::entry_type           rd_ent;
   prit_pkg::entry_type           wr_ent;
   logic [prit_pkg::TIME_W-1:0]   deadline;
   logic [prit_pkg::TIME_W-1:0]   rq_deadline;
   logic                          expired;
   logic                          live;
   logic                          same;
   logic                          rq_ok;
   logic                          ram_wr_en;
   logic [IW-1:0]                 ram_wr_addr;
   logic                          ram_rd_en;
   logic [IW-1:0]                 ram_rd_addr;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_take   = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_idx    = req_fwd_id[IW-1:0];
   assign req_fid_ok = ({1'b0, req_fwd_id} < FID_BOUND);

   assign sw_sum  = {1'b0, next_id_ff} + {1'b0, cnt_ff};
   assign sw_addr = (sw_sum >= ID_LIM) ? IW'(sw_sum - ID_LIM) : sw_sum[IW-1:0];

   assign rd_ent   = prit_pkg::entry_type'(rd_word);
   assign deadline = rd_ent.stamp + max_age_ff;
   assign expired  = chk_vld_ff && (deadline < now_ff);
   assign live     = chk_vld_ff && !expired;
   assign same     = (rd_ent.addr == addr_ff) && (rd_ent.port == port_ff) &&
                     (rd_ent.cid == cid_ff);

   assign rq_deadline = stamp_ff + max_age_ff;
   assign rq_ok       = fid_ok_ff && (rq_deadline > now_ff);

   assign wr_ent.addr  = addr_ff;
   assign wr_ent.port  = port_ff;
   assign wr_ent.cid   = cid_ff;
   assign wr_ent.stamp = stamp_ff;

   assign ram_rd_en   = (state_ff == S_SWEEP) ||
                        (req_take && (req_func == prit_pkg::FUNC_REPLY) && req_fid_ok);
   assign ram_rd_addr = (state_ff == S_SWEEP) ? sw_addr : req_idx;

   prit_ram #(
      .WIDTH (EW),
      .DEPTH (ID_COUNT)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (EW'(wr_ent)),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (rd_word)
   );

   always_comb begin
      state_in      = state_ff;
      max_age_in    = csr_wr_en ? csr_wr_data : max_age_ff;
      next_id_in    = next_id_ff;
      valid_in      = valid_ff;
      cnt_in        = cnt_ff;
      chk_in        = (state_ff == S_SWEEP);
      chk_idx_in    = sw_addr;
      chk_vld_in    = valid_ff[sw_addr];
      dup_found_in  = dup_found_ff;
      dup_idx_in    = dup_idx_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      hit_in        = hit_ff;
      func_in       = func_ff;
      addr_in       = addr_ff;
      port_in       = port_ff;
      cid_in        = cid_ff;
      stamp_in      = stamp_ff;
      now_in        = now_ff;
      fid_idx_in    = fid_idx_ff;
      fid_ok_in     = fid_ok_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_port_in   = rsp_port_ff;
      rsp_cid_in    = rsp_cid_ff;
      rsp_stamp_in  = rsp_stamp_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = free_idx_ff;

      // expire, look for a duplicate and note the first free id, one entry a cycle
      if (chk_ff) begin
         if (expired) begin
            valid_in[chk_idx_ff] = 1'b0;
         end
         if (live && same && (!dup_found_ff || (chk_idx_ff < dup_idx_ff))) begin
            dup_found_in = 1'b1;
            dup_idx_in   = chk_idx_ff;
         end
         if (!live && !free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = chk_idx_ff;
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               func_in    = req_func;
               addr_in    = req_client_addr;
               port_in    = req_client_port;
               cid_in     = req_client_id;
               stamp_in   = req_stamp;
               now_in     = req_now;
               fid_idx_in = req_idx;
               fid_ok_in  = req_fid_ok;
               hit_in     = req_fid_ok && valid_ff[req_idx];
               unique case (req_func)
                  prit_pkg::FUNC_FORWARD: begin
                     state_in      = S_SWEEP;
                     cnt_in        = '0;
                     dup_found_in  = 1'b0;
                     free_found_in = 1'b0;
                  end
                  prit_pkg::FUNC_REPLY: begin
                     state_in = S_REPLY;
                  end
                  prit_pkg::FUNC_REQUEUE,
                  prit_pkg::FUNC_UNUSED: begin
                     state_in = S_SIMPLE;
                  end
               endcase
            end
         end
         S_SWEEP: begin
            if (cnt_ff == ID_LAST) begin
               cnt_in   = '0;
               state_in = S_LAST;
            end else begin
               cnt_in = cnt_ff + IW'(1);
            end
         end
         S_LAST: begin
            state_in = S_FWD_DONE;
         end
         S_FWD_DONE: begin
            if (out_free) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               rsp_addr_in  = '0;
               rsp_port_in  = '0;
               rsp_cid_in   = '0;
               rsp_stamp_in = '0;
               priority if (dup_found_ff) begin
                  rsp_status_in = prit_pkg::ST_DUP;
                  rsp_id_in     = IDW'(dup_idx_ff);
               end else if (free_found_ff) begin
                  ram_wr_en             = 1'b1;
                  ram_wr_addr           = free_idx_ff;
                  valid_in[free_idx_ff] = 1'b1;
                  next_id_in            = (free_idx_ff == ID_LAST) ? '0 : free_idx_ff + IW'(1);
                  rsp_status_in         = prit_pkg::ST_ALLOC;
                  rsp_id_in             = IDW'(free_idx_ff);
               end else begin
                  rsp_status_in = prit_pkg::ST_FULL;
                  rsp_id_in     = '0;
               end
            end
         end
         S_REPLY: begin
            if (out_free) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               if (hit_ff) begin
                  valid_in[fid_idx_ff] = 1'b0;
                  rsp_status_in        = prit_pkg::ST_MATCH;
                  rsp_id_in            = IDW'(fid_idx_ff);
                  rsp_addr_in          = rd_ent.addr;
                  rsp_port_in          = rd_ent.port;
                  rsp_cid_in           = rd_ent.cid;
                  rsp_stamp_in         = rd_ent.stamp;
               end else begin
                  rsp_status_in = prit_pkg::ST_NOMATCH;
                  rsp_id_in     = '0;
                  rsp_addr_in   = '0;
                  rsp_port_in   = '0;
                  rsp_cid_in    = '0;
                  rsp_stamp_in  = '0;
               end
            end
         end
         S_SIMPLE: begin
            if (out_free) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               rsp_id_in    = '0;
               rsp_addr_in  = '0;
               rsp_port_in  = '0;
               rsp_cid_in   = '0;
               rsp_stamp_in = '0;
               priority if (func_ff != prit_pkg::FUNC_REQUEUE) begin
                  rsp_status_in = prit_pkg::ST_NOMATCH;
               end else if (rq_ok) begin
                  ram_wr_en            = 1'b1;
                  ram_wr_addr          = fid_idx_ff;
                  valid_in[fid_idx_ff] = 1'b1;
                  rsp_status_in        = prit_pkg::ST_REQUEUED;
               end else begin
                  rsp_status_in = prit_pkg::ST_STALE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         max_age_ff    <= prit_pkg::MAX_AGE_RST;
         next_id_ff    <= '0;
         valid_ff      <= '0;
         cnt_ff        <= '0;
         chk_ff        <= 1'b0;
         dup_found_ff  <= 1'b0;
         free_found_ff <= 1'b0;
         hit_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         max_age_ff    <= max_age_in;
         next_id_ff    <= next_id_in;
         valid_ff      <= valid_in;
         cnt_ff        <= cnt_in;
         chk_ff        <= chk_in;
         dup_found_ff  <= dup_found_in;
         free_found_ff <= free_found_in;
         hit_ff        <= hit_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      chk_idx_ff    <= chk_idx_in;
      chk_vld_ff    <= chk_vld_in;
      dup_idx_ff    <= dup_idx_in;
      free_idx_ff   <= free_idx_in;
      func_ff       <= func_in;
      addr_ff       <= addr_in;
      port_ff       <= port_in;
      cid_ff        <= cid_in;
      stamp_ff      <= stamp_in;
      now_ff        <= now_in;
      fid_idx_ff    <= fid_idx_in;
      fid_ok_ff     <= fid_ok_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_port_ff   <= rsp_port_in;
      rsp_cid_ff    <= rsp_cid_in;
      rsp_stamp_ff  <= rsp_stamp_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_out_id        = rsp_id_ff;
   assign rsp_out_addr      = rsp_addr_ff;
   assign rsp_out_port      = rsp_port_ff;
   assign rsp_out_client_id = rsp_cid_ff;
   assign rsp_out_stamp     = rsp_stamp_ff;

   a_cnt_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_SWEEP) |-> (cnt_ff == '0))
      else $error("sweep counter running outside the sweep");

   a_hold_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && !req_take) |=> (state_ff == S_IDLE))
      else $error("sequencer left idle without a word");

   a_alloc_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FWD_DONE && out_free && !dup_found_ff && free_found_ff)
      |=> valid_ff[$past(free_idx_ff)])
      else $error("allocated entry not marked valid");

   a_id_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != prit_pkg::ST_ALLOC &&
       rsp_status_ff != prit_pkg::ST_DUP && rsp_status_ff != prit_pkg::ST_MATCH)
      |-> (rsp_id_ff == '0))
      else $error("id reported with a status that carries none");

endmodule

>>> test/pending_request_id_table_unit_tb.sv
// Self-checking bench for pending_request_id_table_unit: a directed table, then phases of
// random words and a fill-and-drain phase at several max_age settings, results checked
// against the table's outcome or a local model. Depends on prit_pkg and the unit's RTL.
module pending_request_id_table_unit_tb;

   localparam int      ID_COUNT  = prit_pkg::ID_COUNT_DEF;
   localparam int      PERIOD    = 10;
   localparam int      KEY_POOL  = 12;
   localparam int      DRILL_LEN = 23;
   localparam int      PHASES    = 7;
   localparam int      FILL_PHASE = 3;
   localparam int      PHASE_LEN = 200;
   localparam longint  RUN_LIMIT = 60_000_000;

   typedef struct packed {
      logic [prit_pkg::FUNC_W-1:0] func;
      logic [prit_pkg::ADDR_W-1:0] addr;
      logic [prit_pkg::PORT_W-1:0] port;
      logic [prit_pkg::CID_W-1:0]  cid;
      logic [prit_pkg::TIME_W-1:0] stamp;
      logic [prit_pkg::TIME_W-1:0] now;
      logic [prit_pkg::FID_W-1:0]  fid;
   } request_word_type;

   typedef struct packed {
      logic [prit_pkg::STATUS_W-1:0] status;
      logic [prit_pkg::ID_W-1:0]     id;
      logic [prit_pkg::ADDR_W-1:0]   addr;
      logic [prit_pkg::PORT_W-1:0]   port;
      logic [prit_pkg::CID_W-1:0]    cid;
      logic [prit_pkg::TIME_W-1:0]   stamp;
   } outcome_type;

   typedef struct {
      request_word_type w;
      bit               typed;
      outcome_type      want;
   } drill_row_type;

   logic                          clock       = 1'b0;
   logic                          reset       = 1'b1;
   logic                          req_valid   = 1'b0;
   logic                          req_stall;
   request_word_type              cur_word    = '0;
   bit                            cur_typed   = 1'b0;
   outcome_type                   cur_want    = '0;
   logic                          rsp_valid;
   logic                          rsp_stall   = 1'b0;
   logic [prit_pkg::STATUS_W-1:0] rsp_status;
   logic [prit_pkg::ID_W-1:0]     rsp_out_id;
   logic [prit_pkg::ADDR_W-1:0]   rsp_out_addr;
   logic [prit_pkg::PORT_W-1:0]   rsp_out_port;
   logic [prit_pkg::CID_W-1:0]    rsp_out_client_id;
   logic [prit_pkg::TIME_W-1:0]   rsp_out_stamp;
   logic                          csr_wr_en   = 1'b0;
   logic [prit_pkg::TIME_W-1:0]   csr_wr_data = '0;

   // model of the table
   logic [prit_pkg::TIME_W-1:0]   age_limit;
   bit                            pending_valid [ID_COUNT];
   prit_pkg::entry_type           pending_entry [ID_COUNT];
   int unsigned                   alloc_ptr;
   outcome_type                   outcome_q [$];

   int unsigned                   error_count = 0;
   logic [prit_pkg::TIME_W-1:0]   wall_s      = '0;
   logic [prit_pkg::ADDR_W-1:0]   pool_addr [KEY_POOL];
   logic [prit_pkg::PORT_W-1:0]   pool_port [KEY_POOL];
   logic [prit_pkg::CID_W-1:0]    pool_cid  [KEY_POOL];
   bit                            steady      = 1'b0;
   int unsigned                   stall_left  = 0;
   int unsigned                   calm_left   = 0;

   pending_request_id_table_unit i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_func          (cur_word.func),
      .req_client_addr   (cur_word.addr),
      .req_client_port   (cur_word.port),
      .req_client_id     (cur_word.cid),
      .req_stamp         (cur_word.stamp),
      .req_now           (cur_word.now),
      .req_fwd_id        (cur_word.fid),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_out_id        (rsp_out_id),
      .rsp_out_addr      (rsp_out_addr),
      .rsp_out_port      (rsp_out_port),
      .rsp_out_client_id (rsp_out_client_id),
      .rsp_out_stamp     (rsp_out_stamp),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   always #(PERIOD / 2) clock = ~clock;

   function automatic request_word_type mk_word(input logic [prit_pkg::FUNC_W-1:0] func,
                                                input logic [prit_pkg::ADDR_W-1:0] addr,
                                                input logic [prit_pkg::PORT_W-1:0] port,
                                                input logic [prit_pkg::CID_W-1:0]  cid,
                                                input logic [prit_pkg::TIME_W-1:0] stamp,
                                                input logic [prit_pkg::TIME_W-1:0] now,
                                                input logic [prit_pkg::FID_W-1:0]  fid);
      request_word_type w;
      w = '{func: func, addr: addr, port: port, cid: cid, stamp: stamp, now: now, fid: fid};
      return w;
   endfunction

   function automatic outcome_type mk_out(input logic [prit_pkg::STATUS_W-1:0] status,
                                          input logic [prit_pkg::ID_W-1:0]     id,
                                          input logic [prit_pkg::ADDR_W-1:0]   addr,
                                          input logic [prit_pkg::PORT_W-1:0]   port,
                                          input logic [prit_pkg::CID_W-1:0]    cid,
                                          input logic [prit_pkg::TIME_W-1:0]   stamp);
      outcome_type r;
      r = '{status: status, id: id, addr: addr, port: port, cid: cid, stamp: stamp};
      return r;
   endfunction

   function automatic outcome_type resolve_word(input request_word_type w);
      outcome_type                 r;
      logic [prit_pkg::TIME_W-1:0] deadline;
      int unsigned                 slot;
      bit                          found;
      r = '0;
      found = 1'b0;
      case (w.func)
         prit_pkg::FUNC_FORWARD: begin
            for (int i = 0; i < ID_COUNT; i++) begin
               deadline = pending_entry[i].stamp + age_limit;
               if (pending_valid[i] && deadline < w.now)
                  pending_valid[i] = 1'b0;
            end
            for (int i = 0; i < ID_COUNT; i++) begin
               if (!found && pending_valid[i] && pending_entry[i].addr == w.addr &&
                   pending_entry[i].port == w.port && pending_entry[i].cid == w.cid) begin
                  r.status = prit_pkg::ST_DUP;
                  r.id = prit_pkg::ID_W'(i);
                  found = 1'b1;
               end
            end
            for (int k = 0; k < ID_COUNT; k++) begin
               slot = (alloc_ptr + k) % ID_COUNT;
               if (!found && !pending_valid[slot]) begin
                  pending_valid[slot] = 1'b1;
                  pending_entry[slot] = '{addr: w.addr, port: w.port, cid: w.cid,
                                          stamp: w.stamp};
                  alloc_ptr = (slot + 1) % ID_COUNT;
                  r.status = prit_pkg::ST_ALLOC;
                  r.id = prit_pkg::ID_W'(slot);
                  found = 1'b1;
               end
            end
            if (!found)
               r.status = prit_pkg::ST_FULL;
         end
         prit_pkg::FUNC_REPLY: begin
            if (w.fid < ID_COUNT && pending_valid[w.fid]) begin
               r = mk_out(prit_pkg::ST_MATCH, prit_pkg::ID_W'(w.fid),
                          pending_entry[w.fid].addr, pending_entry[w.fid].port,
                          pending_entry[w.fid].cid, pending_entry[w.fid].stamp);
               pending_valid[w.fid] = 1'b0;
            end else begin
               r.status = prit_pkg::ST_NOMATCH;
            end
         end
         prit_pkg::FUNC_REQUEUE: begin
            deadline = w.stamp + age_limit;
            if (w.fid < ID_COUNT && deadline > w.now) begin
               pending_valid[w.fid] = 1'b1;
               pending_entry[w.fid] = '{addr: w.addr, port: w.port, cid: w.cid,
                                        stamp: w.stamp};
               r.status = prit_pkg::ST_REQUEUED;
            end else begin
               r.status = prit_pkg::ST_STALE;
            end
         end
         default: r.status = prit_pkg::ST_NOMATCH;
      endcase
      return r;
   endfunction

   task automatic report(input string msg);
      $display("%0t: %s", $time, msg);
      error_count++;
   endtask

   always @(posedge clock) begin : watch_words
      outcome_type got;
      outcome_type want;
      outcome_type calc;
      if (reset) begin
         age_limit = prit_pkg::MAX_AGE_RST;
         alloc_ptr = 0;
         foreach (pending_valid[i])
            pending_valid[i] = 1'b0;
         outcome_q.delete();
      end else begin
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            got = mk_out(rsp_status, rsp_out_id, rsp_out_addr, rsp_out_port,
                         rsp_out_client_id, rsp_out_stamp);
            if (outcome_q.size() == 0) begin
               report($sformatf("result word with nothing outstanding: %h", got));
            end else begin
               want = outcome_q.pop_front();
               if (got.status !== want.status)
                  report($sformatf("status got %0d want %0d", got.status, want.status));
               if (got.id !== want.id)
                  report($sformatf("out_id got %0d want %0d", got.id, want.id));
               if (got.addr !== want.addr)
                  report($sformatf("out_addr got %h want %h", got.addr, want.addr));
               if (got.port !== want.port)
                  report($sformatf("out_port got %h want %h", got.port, want.port));
               if (got.cid !== want.cid)
                  report($sformatf("out_client_id got %h want %h", got.cid, want.cid));
               if (got.stamp !== want.stamp)
                  report($sformatf("out_stamp got %h want %h", got.stamp, want.stamp));
            end
         end
         if (csr_wr_en)
            age_limit = csr_wr_data;
         if (req_valid && req_stall === 1'b0) begin
            calc = resolve_word(cur_word);
            outcome_q.push_back(cur_typed ? cur_want : calc);
         end
      end
   end

   always @(posedge clock) begin : rsp_pacing
      int unsigned roll;
      if (calm_left != 0) begin
         calm_left--;
         rsp_stall <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         roll = $urandom_range(0, 999);
         rsp_stall <= 1'b0;
         if (roll < 3)
            calm_left = $urandom_range(100, 400);
         else if (roll < 15)
            stall_left = $urandom_range(15, 60);
         else if (roll < 300)
            stall_left = $urandom_range(1, 3);
      end
   end

   task automatic send_word(input request_word_type w, input bit typed,
                            input outcome_type want);
      cur_word  <= w;
      cur_typed <= typed;
      cur_want  <= want;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall !== 1'b0);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (outcome_q.size() != 0);
   endtask

   task automatic set_age(input logic [prit_pkg::TIME_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic idle_gap();
      int unsigned roll;
      int unsigned span;
      roll = $urandom_range(0, 999);
      if (steady || roll < 600)
         span = 0;
      else if (roll < 930)
         span = $urandom_range(1, 3);
      else
         span = $urandom_range(8, 40);
      if ($urandom_range(0, 63) == 0)
         steady = !steady;
      if ($urandom_range(0, 199) == 0) begin
         settle();
      end else if (span != 0) begin
         req_valid <= 1'b0;
         repeat (span) @(posedge clock);
      end
   endtask

   function automatic logic [prit_pkg::FID_W-1:0] live_or_any_id();
      int unsigned start;
      start = $urandom_range(0, ID_COUNT - 1);
      if ($urandom_range(0, 9) < 7)
         for (int k = 0; k < ID_COUNT; k++)
            if (pending_valid[(start + k) % ID_COUNT])
               return prit_pkg::FID_W'((start + k) % ID_COUNT);
      return prit_pkg::FID_W'(start);
   endfunction

   function automatic request_word_type random_word();
      request_word_type w;
      int unsigned      pick;
      int unsigned      k;
      pick = $urandom_range(0, 99);
      k = $urandom_range(0, KEY_POOL - 1);
      wall_s = wall_s + prit_pkg::TIME_W'($urandom_range(0, 3));
      w.addr  = pool_addr[k];
      w.port  = pool_port[k];
      w.cid   = pool_cid[k];
      w.now   = wall_s;
      w.stamp = wall_s + prit_pkg::TIME_W'($urandom_range(0, 6)) - prit_pkg::TIME_W'(3);
      w.fid   = live_or_any_id();
      if (pick < 40)
         w.func = prit_pkg::FUNC_FORWARD;
      else if (pick < 70)
         w.func = prit_pkg::FUNC_REPLY;
      else if (pick < 92)
         w.func = prit_pkg::FUNC_REQUEUE;
      else if (pick < 95)
         w.func = prit_pkg::FUNC_UNUSED;
      else
         w = mk_word(prit_pkg::FUNC_W'($urandom), $urandom, prit_pkg::PORT_W'($urandom),
                     prit_pkg::CID_W'($urandom), $urandom, $urandom,
                     prit_pkg::FID_W'($urandom));
      return w;
   endfunction

   initial begin : stimulus
      drill_row_type               drill [DRILL_LEN];
      request_word_type            w;
      logic [prit_pkg::TIME_W-1:0] age;
      drill[0]  = '{mk_word(prit_pkg::FUNC_REPLY, '0, '0, '0, '0, '0, 8'h00), 1'b1,
                    mk_out(prit_pkg::ST_NOMATCH, '0, '0, '0, '0, '0)};
      drill[1]  = '{mk_word(prit_pkg::FUNC_REQUEUE, 32'h0A00_0001, 16'h0714, 8'h07, '1, '0,
                            8'hFF),
                    1'b1, mk_out(prit_pkg::ST_REQUEUED, '0, '0, '0, '0, '0)};
      drill[2]  = '{mk_word(prit_pkg::FUNC_REPLY, '0, '0, '0, '0, '0, 8'hFF), 1'b1,
                    mk_out(prit_pkg::ST_MATCH, 8'hFF, 32'h0A00_0001, 16'h0714, 8'h07, '1)};
      drill[3]  = drill[1];
      // wrapped deadline of the requeued word lapses here
      drill[4]  = '{mk_word(prit_pkg::FUNC_FORWARD, '0, '0, '0, 32'd100, 32'd100, '0), 1'b1,
                    mk_out(prit_pkg::ST_ALLOC, 8'd0, '0, '0, '0, '0)};
      drill[5]  = '{mk_word(prit_pkg::FUNC_REPLY, '0, '0, '0, '0, '0, 8'hFF), 1'b1,
                    mk_out(prit_pkg::ST_NOMATCH, '0, '0, '0, '0, '0)};
      drill[6]  = '{mk_word(prit_pkg::FUNC_FORWARD, '0, '0, '0, 32'd120, 32'd130, '0), 1'b1,
                    mk_out(prit_pkg::ST_DUP, 8'd0, '0, '0, '0, '0)};
      drill[7]  = '{mk_word(prit_pkg::FUNC_FORWARD, '1, '1, '1, '1, 32'd130, '0), 1'b1,
                    mk_out(prit_pkg::ST_ALLOC, 8'd1, '0, '0, '0, '0)};
      drill[8]  = '{mk_word(prit_pkg::FUNC_REPLY, '0, '0, '0, '0, '0, 8'd1), 1'b1,
                    mk_out(prit_pkg::ST_MATCH, 8'd1, '1, '1, '1, '1)};
      drill[9]  = '{mk_word(prit_pkg::FUNC_REPLY, '0, '0, '0, '0, '0, 8'd1), 1'b1,
                    mk_out(prit_pkg::ST_NOMATCH, '0, '0, '0, '0, '0)};
      drill[10] = '{mk_word(prit_pkg::FUNC_REQUEUE, 32'h5555_5555, 16'hAAAA, 8'h55, 32'd100,
                            32'd130, 8'd1),
                    1'b1, mk_out(prit_pkg::ST_STALE, '0, '0, '0, '0, '0)};
      drill[11] = '{mk_word(prit_pkg::FUNC_REQUEUE, 32'h5555_5555, 16'hAAAA, 8'h55, 32'd101,
                            32'd130, 8'd1),
                    1'b1, mk_out(prit_pkg::ST_REQUEUED, '0, '0, '0, '0, '0)};
      drill[12] = '{mk_word(prit_pkg::FUNC_REQUEUE, 32'hAAAA_AAAA, 16'h5555, 8'hAA, 32'd110,
                            32'd131, 8'd1),
                    1'b1, mk_out(prit_pkg::ST_REQUEUED, '0, '0, '0, '0, '0)};
      drill[13] = '{mk_word(prit_pkg::FUNC_REPLY, '0, '0, '0, '0, '0, 8'd1), 1'b1,
                    mk_out(prit_pkg::ST_MATCH, 8'd1, 32'hAAAA_AAAA, 16'h5555, 8'hAA,
                           32'd110)};
      drill[14] = '{mk_word(prit_pkg::FUNC_UNUSED, '1, '1, '1, '1, '1, '1), 1'b1,
                    mk_out(prit_pkg::ST_NOMATCH, '0, '0, '0, '0, '0)};
      drill[15] = '{mk_word(prit_pkg::FUNC_REQUEUE, 32'hC0A8_0001, 16'h0715, 8'h3C, 32'd130,
                            32'd130, 8'd9),
                    1'b1, mk_out(prit_pkg::ST_REQUEUED, '0, '0, '0, '0, '0)};
      drill[16] = '{mk_word(prit_pkg::FUNC_REQUEUE, 32'hC0A8_0001, 16'h0715, 8'h3C, 32'd130,
                            32'd130, 8'd4),
                    1'b1, mk_out(prit_pkg::ST_REQUEUED, '0, '0, '0, '0, '0)};
      // lowest of two live duplicates wins
      drill[17] = '{mk_word(prit_pkg::FUNC_FORWARD, 32'hC0A8_0001, 16'h0715, 8'h3C, 32'd130,
                            32'd131, '0),
                    1'b1, mk_out(prit_pkg::ST_DUP, 8'd4, '0, '0, '0, '0)};
      drill[18] = '{mk_word(prit_pkg::FUNC_FORWARD, '0, '0, '0, 32'd131, 32'd131, '0),
                    1'b0, '0};
      drill[19] = '{mk_word(prit_pkg::FUNC_FORWARD, 32'd1, 16'd2, 8'd3, 32'd131, 32'd131,
                            '0), 1'b0, '0};
      drill[20] = '{mk_word(prit_pkg::FUNC_FORWARD, 32'd1, 16'd2, 8'd4, 32'd131, 32'd131,
                            '0), 1'b0, '0};
      drill[21] = '{mk_word(prit_pkg::FUNC_REPLY, '0, '0, '0, '0, '0, 8'd4), 1'b0, '0};
      drill[22] = '{mk_word(prit_pkg::FUNC_REPLY, '0, '0, '0, '0, '0, 8'd9), 1'b0, '0};

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (drill[r]) begin
         send_word(drill[r].w, drill[r].typed, drill[r].want);
         idle_gap();
      end

      for (int p = 0; p < PHASES; p++) begin
         settle();
         case (p)
            0:       age = 32'd12;
            1:       age = '0;
            2:       age = 32'd7;
            3:       age = '1;
            4:       age = $urandom;
            5:       age = 32'h8000_0000;
            default: age = 32'd1000;
         endcase
         set_age(age);
         wall_s = (p == 2) ? 32'hFFFF_FF00 : $urandom;
         for (int k = 0; k < KEY_POOL; k++) begin
            pool_addr[k] = $urandom;
            pool_port[k] = prit_pkg::PORT_W'($urandom);
            pool_cid[k]  = prit_pkg::CID_W'($urandom);
         end
         if (p == FILL_PHASE) begin
            // fill past capacity with words that never expire, then drain every id
            for (int k = 0; k < ID_COUNT + 8; k++) begin
               w = mk_word(prit_pkg::FUNC_FORWARD, $urandom, prit_pkg::PORT_W'(k),
                           prit_pkg::CID_W'($urandom), '0, $urandom,
                           prit_pkg::FID_W'($urandom));
               send_word(w, 1'b0, '0);
               idle_gap();
            end
            for (int k = 0; k < ID_COUNT; k++) begin
               w = mk_word(prit_pkg::FUNC_REPLY, $urandom, prit_pkg::PORT_W'($urandom),
                           prit_pkg::CID_W'($urandom), $urandom, $urandom,
                           prit_pkg::FID_W'(k));
               send_word(w, 1'b0, '0);
               idle_gap();
            end
         end else begin
            for (int n = 0; n < PHASE_LEN; n++) begin
               w = random_word();
               send_word(w, 1'b0, '0);
               idle_gap();
            end
         end
      end

      settle();
      repeat (ID_COUNT + 8) @(posedge clock);
      if (error_count == 0)
         $display("pending_request_id_table_unit_tb: clean");
      else
         $display("pending_request_id_table_unit_tb: errors");
      $finish;
   end

   initial begin : watchdog
      #(RUN_LIMIT);
      $display("pending_request_id_table_unit_tb: errors");
      $finish;
   end

endmodule
